@@ rtl/core/sll_pkg.sv @@
// Shared action codes, status codes and types for the static linked list engine.
`default_nettype none

package sll_pkg;

    localparam int ACT_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [ACT_W-1:0]    action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_INS_POS = 3'd0;
    localparam action_t ACT_INS_ORD = 3'd1;
    localparam action_t ACT_REM_POS = 3'd2;
    localparam action_t ACT_REM_KEY = 3'd3;
    localparam action_t ACT_READ    = 3'd4;
    localparam action_t ACT_CLEAR   = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_NOKEY = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/sll_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module sll_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/static_linked_list_engine.sv @@
// Top level: linked list over a fixed entry store with a free chain.
//
// Input stream (s_axis): one transfer carries one operation; tuser holds the
// action, tdata holds position and value. Output stream (m_axis): one transfer
// per operation; tuser holds the status, tdata holds the value read or removed,
// the element count and the free count.
// One operation at a time. Each is accepted in S_IDLE; inserts then pass S_FRD to
// fetch the free chain link, then the list is walked one link per cycle from
// the head in S_WALK; removes and inserts then write back the links in S_WR1
// and S_WR2, and S_FIN loads the output register. The walk through the link
// memory sets the length of an operation. Rejected operations and clear go
// straight from accept to S_FIN.
// The result sits in an output register, so the next operation is accepted
// while the result waits; a stalled receiver only holds the block when the
// following result is ready to leave.
// Reset (and clear) empties the list and rebuilds the free chain in index
// order at once through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module static_linked_list_engine #(
    parameter  int LIST_DEPTH  = 64,
    parameter  int VALUE_WIDTH = 32,
    localparam int PW          = $clog2(LIST_DEPTH + 1),
    localparam int IN_DW       = ((PW + VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW      = ((VALUE_WIDTH + 2 * PW + 7) / 8) * 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DW-1:0]     s_axis_tdata,  // position, value
    input  wire sll_pkg::action_t     s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [OUT_DW-1:0]    m_axis_tdata,  // result_value, element_count, free_count
    output sll_pkg::status_t          m_axis_tuser   // status
);

    import sll_pkg::*;

    localparam int            IW        = $clog2(LIST_DEPTH);
    localparam logic [PW-1:0] NULL_LINK = PW'(LIST_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FRD  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_WR1  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]             state_reg, state_next;
    action_t                op_reg, op_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [PW-1:0]          cur_reg, cur_next;
    logic [PW-1:0]          prev_reg, prev_next;
    logic [PW-1:0]          clink_reg, clink_next;
    logic [PW-1:0]          nfree_reg, nfree_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          free_reg, free_next;
    logic [PW-1:0]          cnt_reg, cnt_next;
    logic [LIST_DEPTH-1:0]  vld_reg;
    status_t                status_reg, status_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [VALUE_WIDTH-1:0] m_res_reg, m_res_next;
    logic [PW-1:0]          m_cnt_reg, m_cnt_next;

    logic [IW-1:0]          rd_addr, rd_addr_q;
    logic                   vld_q;
    logic [PW-1:0]          lnk_rdata, lnk_q;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic                   lnk_we, val_we, vld_clr;
    logic [IW-1:0]          lnk_waddr;
    logic [PW-1:0]          lnk_wdata;

    logic [PW-1:0]          in_pos;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   is_full, is_ins, k_lt_cnt, cur_nn, adv;

    assign in_pos = s_axis_tdata[PW-1:0];
    assign in_val = s_axis_tdata[PW +: VALUE_WIDTH];

    // untouched entries still hold their reset link, index + 1
    assign lnk_q = vld_q ? lnk_rdata : (PW'(rd_addr_q) + PW'(1));

    assign is_full  = (cnt_reg == NULL_LINK);
    assign is_ins   = (op_reg == ACT_INS_POS) || (op_reg == ACT_INS_ORD);
    assign k_lt_cnt = (k_reg < cnt_reg);
    assign cur_nn   = (cur_reg != NULL_LINK);

    always_comb
    begin
        case (op_reg)
            ACT_INS_ORD: adv = k_lt_cnt && cur_nn && ($signed(val_reg) > $signed(val_rdata));
            ACT_REM_KEY: adv = k_lt_cnt && cur_nn && (val_rdata != val_reg);
            default:     adv = (k_reg < pos_reg);
        endcase
    end

    sll_ram #(
        .WIDTH (PW),
        .DEPTH (LIST_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (rd_addr),
        .rdata (lnk_rdata)
    );

    sll_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (free_reg[IW-1:0]),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        k_next        = k_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        clink_next    = clink_reg;
        nfree_next    = nfree_reg;
        head_next     = head_reg;
        free_next     = free_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg & ~m_axis_tready;
        m_status_next = m_status_reg;
        m_res_next    = m_res_reg;
        m_cnt_next    = m_cnt_reg;
        rd_addr       = head_reg[IW-1:0];
        lnk_we        = 1'b0;
        lnk_waddr     = cur_reg[IW-1:0];
        lnk_wdata     = free_reg;
        val_we        = 1'b0;
        vld_clr       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    pos_next    = in_pos;
                    val_next    = in_val;
                    k_next      = '0;
                    prev_next   = NULL_LINK;
                    cur_next    = head_reg;
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    case (s_axis_tuser)
                        ACT_INS_POS:
                        begin
                            if (in_pos > cnt_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                rd_addr    = free_reg[IW-1:0];
                                state_next = S_FRD;
                            end
                        end
                        ACT_INS_ORD:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                rd_addr    = free_reg[IW-1:0];
                                state_next = S_FRD;
                            end
                        end
                        ACT_REM_POS, ACT_READ:
                        begin
                            if ((cnt_reg == '0) || (in_pos >= cnt_reg))
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_REM_KEY:
                        begin
                            state_next = S_WALK;
                        end
                        ACT_CLEAR:
                        begin
                            head_next = NULL_LINK;
                            free_next = '0;
                            cnt_next  = '0;
                            vld_clr   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FRD:
            begin
                nfree_next = lnk_q;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (adv)
                begin
                    rd_addr   = lnk_q[IW-1:0];
                    prev_next = cur_reg;
                    cur_next  = lnk_q;
                    k_next    = k_reg + PW'(1);
                end
                else
                begin
                    clink_next = lnk_q;
                    state_next = S_WR1;
                    case (op_reg)
                        ACT_READ:
                        begin
                            res_next   = val_rdata;
                            state_next = S_FIN;
                        end
                        ACT_REM_KEY:
                        begin
                            if (!k_lt_cnt || !cur_nn)
                            begin
                                status_next = ST_NOKEY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                res_next = val_rdata;
                            end
                        end
                        ACT_REM_POS:
                        begin
                            res_next = val_rdata;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WR1:
            begin
                if (is_ins)
                begin
                    lnk_we    = 1'b1;
                    lnk_waddr = free_reg[IW-1:0];
                    lnk_wdata = cur_reg;
                    val_we    = 1'b1;
                end
                else if (prev_reg != NULL_LINK)
                begin
                    lnk_we    = 1'b1;
                    lnk_waddr = prev_reg[IW-1:0];
                    lnk_wdata = clink_reg;
                end
                else
                begin
                    head_next = clink_reg;
                end
                state_next = S_WR2;
            end
            S_WR2:
            begin
                if (is_ins)
                begin
                    if (prev_reg != NULL_LINK)
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = prev_reg[IW-1:0];
                        lnk_wdata = free_reg;
                    end
                    else
                    begin
                        head_next = free_reg;
                    end
                    free_next = nfree_reg;
                    cnt_next  = cnt_reg + PW'(1);
                end
                else
                begin
                    lnk_we    = 1'b1;
                    lnk_waddr = cur_reg[IW-1:0];
                    lnk_wdata = free_reg;
                    free_next = cur_reg;
                    cnt_next  = cnt_reg - PW'(1);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_res_next    = res_reg;
                    m_cnt_next    = cnt_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= NULL_LINK;
            free_reg    <= '0;
            cnt_reg     <= '0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (vld_clr)
            begin
                vld_reg <= '0;
            end
            else if (lnk_we)
            begin
                vld_reg[lnk_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        clink_reg    <= clink_next;
        nfree_reg    <= nfree_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_res_reg    <= m_res_next;
        m_cnt_reg    <= m_cnt_next;
        rd_addr_q    <= rd_addr;
        vld_q        <= vld_reg[rd_addr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = OUT_DW'({NULL_LINK - m_cnt_reg, m_cnt_reg, m_res_reg});

endmodule

`default_nettype wire

@@ rtl/core/sll_checker.sv @@
// Port-level checker for the static linked list engine, bound to the top level.
`default_nettype none

module sll_checker #(
    parameter  int LIST_DEPTH  = 64,
    parameter  int VALUE_WIDTH = 32,
    localparam int PW          = $clog2(LIST_DEPTH + 1),
    localparam int OUT_DW      = ((VALUE_WIDTH + 2 * PW + 7) / 8) * 8
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_DW-1:0] m_axis_tdata,
    input wire sll_pkg::status_t  m_axis_tuser
);

    import sll_pkg::*;

    logic [VALUE_WIDTH-1:0] out_res;
    logic [PW:0]            out_cnt, out_free;

    assign out_res  = m_axis_tdata[VALUE_WIDTH-1:0];
    assign out_cnt  = {1'b0, m_axis_tdata[VALUE_WIDTH +: PW]};
    assign out_free = {1'b0, m_axis_tdata[VALUE_WIDTH + PW +: PW]};

    // one operation in flight: a transfer in always blocks the next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted back to back");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_cnt + out_free) == (PW + 1)'(LIST_DEPTH)))
        else $error("element and free counts do not cover the store");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (out_res == '0))
        else $error("failed operation returned a value");

    a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (out_free == '0))
        else $error("full status with free entries left");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind static_linked_list_engine sll_checker #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_sll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ dv/sll_result_checker.sv @@
// Scoreboard for the static linked list engine: mirrors the list and checks every result.
`timescale 1ns / 100ps

module sll_result_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,  // position, value
    input  sll_pkg::action_t s_axis_tuser,  // action
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [47:0]      m_axis_tdata,  // result_value, element_count, free_count
    input  sll_pkg::status_t m_axis_tuser,  // status
    output int               fail_count,
    output int               outstanding,
    output int               compared,
    output int               full_seen
);
    import sll_pkg::*;

    localparam int         DEPTH = 64;
    localparam logic [6:0] NIL   = 7'd64;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [6:0]  elements;
        logic [6:0]  free_cnt;
    } list_result_t;

    logic [31:0]  node_value [DEPTH];
    logic [6:0]   node_link  [DEPTH];
    logic [6:0]   head_idx;
    logic [6:0]   free_idx;
    logic [6:0]   used;
    list_result_t expected_results [$];

    function automatic logic [6:0] next_of(logic [6:0] i);
        return (i < NIL) ? node_link[i[5:0]] : NIL;
    endfunction

    task automatic reset_chains();
        for (int i = 0; i < DEPTH; i++)
            node_link[i] = (i == DEPTH - 1) ? NIL : 7'(i + 1);
        head_idx = NIL;
        free_idx = '0;
        used     = '0;
    endtask

    function automatic logic [6:0] take_node(logic [31:0] v);
        logic [6:0] n;
        n                = free_idx;
        free_idx         = next_of(n);
        node_value[n[5:0]] = v;
        used             = used + 7'd1;
        return n;
    endfunction

    task automatic give_node(input logic [6:0] n);
        node_link[n[5:0]] = free_idx;
        free_idx          = n;
        if (used > 0)
            used = used - 7'd1;
    endtask

    task automatic splice_in(input logic [6:0] n, input logic [6:0] prev,
                             input logic [6:0] cur);
        if (prev == NIL)
        begin
            node_link[n[5:0]] = head_idx;
            head_idx          = n;
        end
        else
        begin
            node_link[n[5:0]]    = cur;
            node_link[prev[5:0]] = n;
        end
    endtask

    task automatic splice_out(input logic [6:0] prev, input logic [6:0] cur);
        if (prev == NIL)
            head_idx = next_of(cur);
        else
            node_link[prev[5:0]] = next_of(cur);
    endtask

    task automatic apply_list_op(input action_t act, input logic [6:0] pos,
                                 input logic [31:0] v, output list_result_t r);
        logic [6:0] prev;
        logic [6:0] cur;
        logic [6:0] n;
        int         k;
        r    = '0;
        prev = NIL;
        cur  = head_idx;
        k    = 0;
        case (act)
            ACT_INS_POS:
            begin
                if (pos > used)
                    r.status = ST_RANGE;
                else if (used >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    n = take_node(v);
                    for (k = 0; k < pos; k++)
                    begin
                        prev = cur;
                        cur  = next_of(cur);
                    end
                    splice_in(n, prev, cur);
                end
            end
            ACT_INS_ORD:
            begin
                if (used >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    while (k < used && cur != NIL &&
                           $signed(v) > $signed(node_value[cur[5:0]]))
                    begin
                        prev = cur;
                        cur  = next_of(cur);
                        k++;
                    end
                    n = take_node(v);
                    splice_in(n, prev, cur);
                end
            end
            ACT_REM_POS:
            begin
                if (used == 0 || pos >= used)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = 0; k < pos; k++)
                    begin
                        prev = cur;
                        cur  = next_of(cur);
                    end
                    splice_out(prev, cur);
                    r.value = node_value[cur[5:0]];
                    give_node(cur);
                end
            end
            ACT_REM_KEY:
            begin
                while (k < used && cur != NIL && node_value[cur[5:0]] != v)
                begin
                    prev = cur;
                    cur  = next_of(cur);
                    k++;
                end
                if (k >= used || cur == NIL)
                    r.status = ST_NOKEY;
                else
                begin
                    splice_out(prev, cur);
                    r.value = node_value[cur[5:0]];
                    give_node(cur);
                end
            end
            ACT_READ:
            begin
                if (used == 0 || pos >= used)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = 0; k < pos; k++)
                        cur = next_of(cur);
                    r.value = node_value[cur[5:0]];
                end
            end
            ACT_CLEAR:
                reset_chains();
            default:
            begin
            end
        endcase
        r.elements = used;
        r.free_cnt = 7'(DEPTH - used);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t got;
        int           errs;
        if (!rst_n)
        begin
            reset_chains();
            expected_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
            compared    <= 0;
            full_seen   <= 0;
        end
        else
        begin
            errs = 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status   = m_axis_tuser;
                got.value    = m_axis_tdata[31:0];
                got.elements = m_axis_tdata[38:32];
                got.free_cnt = m_axis_tdata[45:39];
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no operation pending");
                    errs++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.value != want.value)
                    begin
                        $error("result_value expected %0d actual %0d",
                               $signed(want.value), $signed(got.value));
                        errs++;
                    end
                    if (got.elements != want.elements)
                    begin
                        $error("element_count expected %0d actual %0d",
                               want.elements, got.elements);
                        errs++;
                    end
                    if (got.free_cnt != want.free_cnt)
                    begin
                        $error("free_count expected %0d actual %0d",
                               want.free_cnt, got.free_cnt);
                        errs++;
                    end
                    compared <= compared + 1;
                    if (want.status == ST_FULL)
                        full_seen <= full_seen + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_list_op(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[38:7], want);
                expected_results.push_back(want);
            end
            fail_count  <= fail_count + errs;
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the static linked list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import sll_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEMS       = 850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    action_t     s_axis_tuser  = ACT_READ;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    status_t     m_axis_tuser;

    int fail_count;
    int outstanding;
    int compared;
    int full_seen;
    int sent      = 0;
    int cycles    = 0;
    bit steady    = 1'b0;
    bit hold_done = 1'b0;

    static_linked_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sll_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .compared      (compared),
        .full_seen     (full_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("static_linked_list_engine: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off mid-run
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= 500)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:          return 32'h8000_0000;
            1:          return 32'h7fff_ffff;
            2, 3, 4, 5: return $urandom_range(0, 15) - 32'd8;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        case ($urandom_range(0, 9))
            0:          return 7'($urandom_range(0, 127));
            1, 2, 3, 4: return 7'($urandom_range(0, 66));
            default:    return 7'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic send_op(input action_t act, input logic [6:0] pos, input logic [31:0] v);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, v, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        steady = (sent >= 300 && sent < 420);
    endtask

    initial
    begin
        action_t act;
        int      roll;
        int      phase_left;
        bit      filling;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases, then a small list built by position and by order
        send_op(ACT_READ,    7'd0,   32'd0);
        send_op(ACT_REM_POS, 7'd0,   32'd0);
        send_op(ACT_REM_KEY, 7'd0,   32'd0);
        send_op(ACT_INS_POS, 7'd1,   32'd9);
        send_op(ACT_INS_POS, 7'd0,   32'h8000_0000);
        send_op(ACT_INS_ORD, 7'd0,   32'h7fff_ffff);
        send_op(ACT_INS_ORD, 7'd0,   32'h8000_0000);
        send_op(ACT_INS_ORD, 7'd0,   32'd0);
        send_op(ACT_INS_POS, 7'd4,   32'hffff_ffff);
        send_op(ACT_INS_POS, 7'd127, 32'd1);
        send_op(ACT_READ,    7'd0,   32'd0);
        send_op(ACT_READ,    7'd4,   32'd0);
        send_op(ACT_READ,    7'd5,   32'd0);
        send_op(ACT_READ,    7'd127, 32'd0);
        send_op(ACT_REM_KEY, 7'd0,   32'd0);
        send_op(ACT_REM_KEY, 7'd0,   32'd12345);
        send_op(ACT_REM_POS, 7'd3,   32'd0);
        send_op(ACT_REM_POS, 7'd3,   32'd0);
        send_op(action_t'(6), 7'd0,  32'd0);
        send_op(action_t'(7), 7'd127, 32'hffff_ffff);
        send_op(ACT_REM_POS, 7'd0,   32'd0);
        send_op(ACT_CLEAR,   7'd0,   32'd0);
        send_op(ACT_READ,    7'd0,   32'd0);
        send_op(ACT_INS_ORD, 7'd0,   32'd5);
        send_op(ACT_REM_KEY, 7'd0,   32'd5);

        // alternate fill and drain phases so the list reaches full and empty
        filling    = 1'b1;
        phase_left = $urandom_range(100, 220);
        while (sent < ITEMS)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(100, 220);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 1)
                act = ACT_CLEAR;
            else if (roll < 3)
                act = action_t'($urandom_range(6, 7));
            else if (roll < 13)
                act = ACT_READ;
            else if (roll < (filling ? 88 : 38))
                act = $urandom_range(0, 1) ? ACT_INS_ORD : ACT_INS_POS;
            else
                act = $urandom_range(0, 1) ? ACT_REM_KEY : ACT_REM_POS;
            send_op(act, pick_position(), pick_value());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);

        $display("%0d operations sent over fill, drain and clear phases", sent);
        $display("%0d results compared, %0d against a full list", compared, full_seen);
        if (fail_count == 0)
            $display("static_linked_list_engine: match");
        else
            $display("static_linked_list_engine: mismatch");
        $finish;
    end

endmodule
